/* rtl/core/mi_pkg.sv */
// shared constants, types and register map of the modular inverse block
package mi_pkg;

  // operand width and derived widths
  localparam int DATA_WIDTH = 31;
  localparam int COEF_WIDTH = DATA_WIDTH + 3;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
  localparam int APB_WIDTH  = 32;
  localparam int ADDR_WIDTH = 2;

  // register map
  localparam logic [ADDR_WIDTH-1:0] ADDR_MODULUS = '0;
  localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(65537);

  typedef logic [DATA_WIDTH-1:0]        word_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic [CNT_WIDTH-1:0]         cnt_t;

  // operand select and mode for the shared subtract unit
  typedef struct packed {
    logic rem_shifted;
    logic coef_add;
    logic coef_modulus;
  } alu_ctrl_t;

  // one finished result word
  typedef struct packed {
    word_t inverse;
    word_t common_divisor;
    logic  no_inverse;
  } result_t;

endpackage

/* rtl/core/mi_alu.sv */
// shared subtract unit: remainder lane and signed coefficient lane
module mi_alu (
  input  mi_pkg::alu_ctrl_t ctrl,
  input  mi_pkg::word_t     rem_x,
  input  mi_pkg::word_t     rem_d,
  input  mi_pkg::coef_t     coef_x,
  input  mi_pkg::coef_t     coef_e,
  input  mi_pkg::word_t     modulus,
  output mi_pkg::word_t     rem_diff,
  output logic              rem_neg,
  output mi_pkg::coef_t     coef_res
);
  import mi_pkg::*;

  logic [DATA_WIDTH:0]   rem_y;
  logic [DATA_WIDTH+1:0] rem_full;
  coef_t                 coef_y;

  // remainder lane: x minus divisor, or minus twice the divisor for the alignment test
  assign rem_y    = ctrl.rem_shifted ? {rem_d, 1'b0} : {1'b0, rem_d};
  assign rem_full = {2'b00, rem_x} - {1'b0, rem_y};
  assign rem_diff = rem_full[DATA_WIDTH-1:0];
  assign rem_neg  = rem_full[DATA_WIDTH+1];

  // coefficient lane: add or subtract the shifted coefficient or the modulus
  assign coef_y   = ctrl.coef_modulus ?
                    $signed({{(COEF_WIDTH-DATA_WIDTH){1'b0}}, modulus}) : coef_e;
  assign coef_res = ctrl.coef_add ? (coef_x + coef_y) : (coef_x - coef_y);

endmodule

/* rtl/core/mi_core.sv */
// sequencer and working registers of the extended euclid iteration
module mi_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start_valid,
  output logic            start_ready,
  input  mi_pkg::word_t   val,
  input  mi_pkg::word_t   modulus,
  output logic            res_valid,
  input  logic            res_ready,
  output mi_pkg::result_t res
);
  import mi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_SUB,
    S_REDUCE,
    S_DONE
  } state_t;

  state_t    state;
  word_t     a, b, d, m;
  coef_t     sa, sb, e;
  cnt_t      k;
  alu_ctrl_t ctrl;
  word_t     rem_diff;
  logic      rem_neg;
  coef_t     coef_res;
  word_t     rem_new;
  coef_t     coef_new;

  // operand selection for the shared unit
  always_comb begin
    ctrl.rem_shifted  = (state == S_SHIFT);
    ctrl.coef_modulus = (state == S_REDUCE);
    ctrl.coef_add     = (state == S_REDUCE) && sb[COEF_WIDTH-1];
  end

  mi_alu u_alu (
    .ctrl     (ctrl),
    .rem_x    (b),
    .rem_d    (d),
    .coef_x   (sb),
    .coef_e   (e),
    .modulus  (m),
    .rem_diff (rem_diff),
    .rem_neg  (rem_neg),
    .coef_res (coef_res)
  );

  // one restoring subtract step of the current quotient
  always_comb begin
    rem_new  = rem_neg ? b  : rem_diff;
    coef_new = rem_neg ? sb : coef_res;
  end

  // sequencer: align divisor, subtract down bit by bit, swap, then reduce
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start_valid) begin
            a     <= val;
            b     <= modulus;
            m     <= modulus;
            sa    <= coef_t'(1);
            sb    <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (a == '0) begin
            if (m == '0) begin
              sb    <= '0;
              state <= S_DONE;
            end else begin
              state <= S_REDUCE;
            end
          end else begin
            d     <= a;
            e     <= sa;
            k     <= '0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // keep doubling while twice the divisor still fits under the remainder
          if (!rem_neg) begin
            d <= {d[DATA_WIDTH-2:0], 1'b0};
            e <= e <<< 1;
            k <= k + cnt_t'(1);
          end else begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (k == '0) begin
            // quotient done: remainder becomes the new divisor
            a     <= rem_new;
            b     <= a;
            sa    <= coef_new;
            sb    <= sa;
            state <= S_CHECK;
          end else begin
            b <= rem_new;
            sb <= coef_new;
            d <= d >> 1;
            e <= e >>> 1;
            k <= k - cnt_t'(1);
          end
        end
        S_REDUCE: begin
          // bring the coefficient into 0..m-1
          if (sb[COEF_WIDTH-1]) begin
            sb <= coef_res;
          end else if (!coef_res[COEF_WIDTH-1]) begin
            sb <= coef_res;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // handshake and result word
  assign start_ready        = (state == S_IDLE);
  assign res_valid          = (state == S_DONE);
  assign res.inverse        = sb[DATA_WIDTH-1:0];
  assign res.common_divisor = b;
  assign res.no_inverse     = (b != word_t'(1));

endmodule

/* rtl/core/modular_inverse_ext_gcd.sv */
// Modular inverse by the extended Euclidean algorithm. Each input word carries one
// value; the block returns the Bezout coefficient of that value reduced into
// 0..modulus-1, gcd(value, modulus) and a flag that is set when the gcd is not 1.
// A modulus of zero gives an inverse of 0 and the value as gcd. The modulus is
// written over the APB port at byte address 0; the user must write it only while the
// block is idle, which the block itself does not enforce. One word is worked on at
// a time: each Euclid quotient step is a check, then the divisor is doubled on the
// shared subtract unit up to the top power of two in that quotient and subtracted
// back down bit by bit; a closing check, the final reduction and a hand-over follow.
// The finished word sits in an output register, so the next value is accepted
// while it waits to be taken.
module modular_inverse_ext_gcd (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mi_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [mi_pkg::APB_WIDTH-1:0]        pwdata,
  output logic [mi_pkg::APB_WIDTH-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mi_pkg::DATA_WIDTH-1:0]       value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mi_pkg::DATA_WIDTH-1:0]       inverse,
  output logic [mi_pkg::DATA_WIDTH-1:0]       common_divisor,
  output logic                                no_inverse
);
  import mi_pkg::*;

  word_t   modulus;
  logic    core_valid;
  logic    core_ready;
  result_t core_res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MODULUS) ?
                  {{(APB_WIDTH-DATA_WIDTH){1'b0}}, modulus} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MODULUS)) begin
      modulus <= pwdata[DATA_WIDTH-1:0];
    end
  end

  mi_core u_core (
    .clk         (clk),
    .rst         (rst),
    .start_valid (in_valid),
    .start_ready (in_ready),
    .val         (value),
    .modulus     (modulus),
    .res_valid   (core_valid),
    .res_ready   (core_ready),
    .res         (core_res)
  );

  // output register decouples the result word from the next computation
  assign core_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_valid && core_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      inverse        <= core_res.inverse;
      common_divisor <= core_res.common_divisor;
      no_inverse     <= core_res.no_inverse;
    end
  end

endmodule
